// ----- rtl/ebs_pkg.sv -----
// shared constants and types for the edge clamped box smoother
package ebs_pkg;
  localparam int MAX_RADIUS = 15;
  localparam int WDEPTH     = 2 * MAX_RADIUS + 1;
  localparam int IDX_W      = $clog2(WDEPTH);
  localparam int RAD_W      = $clog2(MAX_RADIUS + 1);
  localparam int SUM_W      = 21;
  localparam int COORD_W    = 16;
  localparam int POINT_W    = 2 * COORD_W;
  localparam int DIV_W      = $clog2(WDEPTH + 1);
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 4;

  localparam logic [CFG_IDX_W-1:0] REG_RADIUS = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_AXIS   = 1'd1;

  typedef logic [POINT_W-1:0] point_t;
endpackage

// ----- rtl/ebs_cell.sv -----
// one cell of the point shift chain
module ebs_cell (
  input  logic           clk_i,
  input  logic           shift_i,
  input  ebs_pkg::point_t pt_i,
  output ebs_pkg::point_t pt_o
);
  import ebs_pkg::*;

  point_t pt_q;

  always_ff @(posedge clk_i) begin
    if (shift_i) begin
      pt_q <= pt_i;
    end
  end

  assign pt_o = pt_q;
endmodule

// ----- rtl/ebs_div.sv -----
// iterative signed divider, one quotient bit per cycle, truncating toward zero
module ebs_div (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             start_i,
  input  logic signed [ebs_pkg::SUM_W-1:0] dividend_i,
  input  logic [ebs_pkg::DIV_W-1:0]        divisor_i,
  output logic                             done_o,
  output logic signed [ebs_pkg::COORD_W-1:0] quot_o
);
  import ebs_pkg::*;

  localparam int CNT_W = $clog2(SUM_W + 1);

  logic [SUM_W-1:0] mag_q;
  logic [DIV_W:0]   rem_q;
  logic [DIV_W-1:0] dvs_q;
  logic             neg_q;
  logic [CNT_W-1:0] cnt_q;
  logic             done_q;
  logic [DIV_W:0]   rem_sh;
  logic             fits;
  logic [SUM_W-1:0] neg_mag;

  assign rem_sh  = {rem_q[DIV_W-1:0], mag_q[SUM_W-1]};
  assign fits    = rem_sh >= {1'b0, dvs_q};
  assign neg_mag = SUM_W'(0) - mag_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        cnt_q <= CNT_W'(SUM_W);
      end else if (cnt_q != '0) begin
        cnt_q <= cnt_q - CNT_W'(1);
        if (cnt_q == CNT_W'(1)) begin
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      neg_q <= dividend_i[SUM_W-1];
      mag_q <= dividend_i[SUM_W-1] ? SUM_W'(0) - SUM_W'(dividend_i) : SUM_W'(dividend_i);
      rem_q <= '0;
      dvs_q <= divisor_i;
    end else if (cnt_q != '0) begin
      rem_q <= fits ? rem_sh - {1'b0, dvs_q} : rem_sh;
      mag_q <= {mag_q[SUM_W-2:0], fits};
    end
  end

  assign done_o = done_q;
  assign quot_o = neg_q ? COORD_W'(neg_mag) : COORD_W'(mag_q);

`ifndef SYNTHESIS
  a_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |-> cnt_q == '0) else $error("divider restarted while busy");
  a_done_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> $past(cnt_q) == CNT_W'(1)) else $error("divider done out of step");
  a_no_start_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |=> !done_q) else $error("divider done right after start");
`endif
endmodule

// ----- rtl/edge_clamped_box_smoother_core.sv -----
// edge clamped box smoother top level: cell chain, sum sequencer, divider, output register
//  channel  | handshake                    | payload
//  s_axis   | s_axis_tvalid/s_axis_tready  | tdata {y,x}, tlast last_point
//  m_axis   | m_axis_tvalid/m_axis_tready  | tdata {y,x}, tlast last_result
//  cfg      | cfg_we_i                     | cfg_idx_i, cfg_data_i
// each result sums the 2r+1 window points over the cell chain read port, reads the
// center point, runs the bit-serial divider and loads the output register; the core
// is ready for the next item once the output register has been loaded;
// a last item releases all pending results back to back in that way.
// an item is taken only while no result is being computed; the output register lets
// one finished result wait for m_axis_tready. reset clears control state only.
module edge_clamped_box_smoother_core (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  input  logic [ebs_pkg::POINT_W-1:0]    s_axis_tdata,   // point_x, point_y
  input  logic                           s_axis_tlast,
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  output logic [ebs_pkg::POINT_W-1:0]    m_axis_tdata,   // smoothed_x, smoothed_y
  output logic                           m_axis_tlast,
  input  logic                           cfg_we_i,
  input  logic [ebs_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [ebs_pkg::CFG_DATA_W-1:0] cfg_data_i
);
  import ebs_pkg::*;

  typedef enum logic [2:0] {S_IDLE, S_SUM, S_CTR, S_DIV, S_OUT} state_e;

  state_e           state_q;
  logic [RAD_W-1:0] cfg_rad_q, run_rad_q, d_q, nidx_q;
  logic             cfg_axis_q, run_axis_q, in_run_q, flush_q;
  logic [IDX_W-1:0] seen_q, k_q;
  logic signed [SUM_W-1:0] acc_q;
  point_t           ctr_q;
  logic             out_valid_q, out_last_q;
  point_t           out_pt_q;

  point_t           chain [WDEPTH];
  logic             accept;
  logic [RAD_W-1:0] rad_eff;
  logic [IDX_W-1:0] seen_new;
  logic signed [IDX_W+1:0] back;
  logic [IDX_W-1:0] hi_lim, sel_idx, rd_idx;
  point_t           rd_pt;
  logic signed [COORD_W-1:0] sample, avg;
  logic             div_start, div_done, out_load;
  point_t           result;

  assign accept        = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = state_q == S_IDLE;

  // shift chain: cell 0 holds the newest point
  for (genvar g = 0; g < WDEPTH; g++) begin : g_cell
    if (g == 0) begin : g_head
      ebs_cell u_cell (.clk_i, .shift_i(accept), .pt_i(s_axis_tdata), .pt_o(chain[g]));
    end else begin : g_body
      ebs_cell u_cell (.clk_i, .shift_i(accept), .pt_i(chain[g-1]), .pt_o(chain[g]));
    end
  end

  assign rad_eff  = in_run_q ? run_rad_q : cfg_rad_q;
  assign seen_new = (in_run_q ? seen_q : IDX_W'(0)) + IDX_W'(1);

  // window tap distance behind the newest point, clamped to newest and to run start
  assign back    = (IDX_W+2)'(d_q) + (IDX_W+2)'(run_rad_q) - (IDX_W+2)'(k_q);
  assign hi_lim  = IDX_W'(d_q) + IDX_W'(nidx_q);
  always_comb begin
    if (back < 0) begin
      sel_idx = '0;
    end else if (back > (IDX_W+2)'(hi_lim)) begin
      sel_idx = hi_lim;
    end else begin
      sel_idx = back[IDX_W-1:0];
    end
  end
  assign rd_idx = (state_q == S_CTR) ? IDX_W'(d_q) : sel_idx;
  assign rd_pt  = chain[rd_idx];
  assign sample = run_axis_q ? rd_pt[POINT_W-1:COORD_W] : rd_pt[COORD_W-1:0];

  assign div_start = state_q == S_CTR;

  ebs_div u_div (
    .clk_i, .rst_ni,
    .start_i(div_start),
    .dividend_i(acc_q),
    .divisor_i(DIV_W'({run_rad_q, 1'b1})),
    .done_o(div_done),
    .quot_o(avg)
  );

  assign result   = run_axis_q ? {avg, ctr_q[COORD_W-1:0]} : {ctr_q[POINT_W-1:COORD_W], avg};
  assign out_load = state_q == S_OUT && (!out_valid_q || m_axis_tready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cfg_rad_q   <= '0;
      cfg_axis_q  <= 1'b0;
      run_rad_q   <= '0;
      run_axis_q  <= 1'b0;
      in_run_q    <= 1'b0;
      flush_q     <= 1'b0;
      seen_q      <= '0;
      nidx_q      <= '0;
      d_q         <= '0;
      k_q         <= '0;
      out_valid_q <= 1'b0;
      out_last_q  <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          REG_RADIUS: cfg_rad_q  <= RAD_W'(cfg_data_i);
          REG_AXIS:   cfg_axis_q <= cfg_data_i[0];
          default: ;
        endcase
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (accept) begin
            if (!in_run_q) begin
              run_rad_q  <= cfg_rad_q;
              run_axis_q <= cfg_axis_q;
              nidx_q     <= '0;
              in_run_q   <= 1'b1;
            end
            k_q <= '0;
            if (s_axis_tlast) begin
              flush_q <= 1'b1;
              d_q     <= RAD_W'(seen_new - IDX_W'(1));
              state_q <= S_SUM;
            end else if (seen_new > IDX_W'(rad_eff)) begin
              flush_q <= 1'b0;
              d_q     <= rad_eff;
              seen_q  <= IDX_W'(rad_eff);
              state_q <= S_SUM;
            end else begin
              seen_q <= seen_new;
            end
          end
        end
        S_SUM: begin
          k_q <= k_q + IDX_W'(1);
          if (k_q == IDX_W'({run_rad_q, 1'b0})) begin
            state_q <= S_CTR;
          end
        end
        S_CTR: state_q <= S_DIV;
        S_DIV: begin
          if (div_done) begin
            state_q <= S_OUT;
          end
        end
        S_OUT: begin
          if (out_load) begin
            out_last_q  <= flush_q && d_q == '0;
            k_q         <= '0;
            if (flush_q && d_q != '0) begin
              d_q     <= d_q - RAD_W'(1);
              state_q <= S_SUM;
              if (nidx_q != RAD_W'(MAX_RADIUS)) begin
                nidx_q <= nidx_q + RAD_W'(1);
              end
            end else begin
              state_q <= S_IDLE;
              if (flush_q) begin
                in_run_q <= 1'b0;
                seen_q   <= '0;
                nidx_q   <= '0;
              end else if (nidx_q != RAD_W'(MAX_RADIUS)) begin
                nidx_q <= nidx_q + RAD_W'(1);
              end
            end
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (state_q == S_SUM) begin
      acc_q <= (k_q == '0 ? SUM_W'(0) : acc_q) + SUM_W'(sample);
    end
    if (state_q == S_CTR) begin
      ctr_q <= rd_pt;
    end
    if (out_load) begin
      out_pt_q <= result;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_pt_q;
  assign m_axis_tlast  = out_last_q;

`ifndef SYNTHESIS
  a_seen_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_run_q |-> seen_q <= IDX_W'(run_rad_q)) else $error("pending count above radius");
  a_done_in_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> state_q == S_DIV) else $error("divider done outside divide state");
  a_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |-> !m_axis_tvalid || m_axis_tready) else $error("output overwritten");
`endif
endmodule
